[src/goc_pkg.sv]
package goc_pkg;

  // Width of every configuration register.
  localparam int unsigned RegW = 16;

  // Reset values of the configuration registers.
  localparam logic [RegW-1:0] MoveTimeoutRst   = 16'd400;
  localparam logic [RegW-1:0] EmergHoldRst     = 16'd100;
  localparam logic [RegW-1:0] BlinkFastRst     = 16'd5;
  localparam logic [RegW-1:0] BlinkSlowRst     = 16'd10;
  localparam logic [RegW-1:0] ErrorBeepRst     = 16'd10;

  // One request on the input stream.
  typedef struct packed {
    logic       op;
    logic       limit_open;
    logic       limit_closed;
    logic       obstruction;
    logic [2:0] command;
  } goc_item_t;

  // One result on the output stream.
  typedef struct packed {
    logic [3:0] gate_state;
    logic       motor_open;
    logic       motor_close;
    logic       buzzer;
    logic       lamp;
  } goc_result_t;

  // Current configuration as seen by the controller.
  typedef struct packed {
    logic [RegW-1:0] move_timeout_ticks;
    logic [RegW-1:0] emergency_hold_ticks;
    logic [RegW-1:0] blink_fast_ticks;
    logic [RegW-1:0] blink_slow_ticks;
    logic [RegW-1:0] error_beep_ticks;
  } goc_cfg_t;

endpackage

[src/gate_opener_controller.sv]
// Gate opener controller. Requests come in on the slave stream: a tick (tuser 0) samples
// the open limit, closed limit and obstruction sensors and advances the movement, blink,
// beep and emergency hold counters; a command (tuser 1) carries open, close, stop, reset
// or emergency. Every request yields exactly one result giving the gate state after the
// update, the motor directions and the buzzer and lamp levels. The block takes one
// request per clock cycle while the master side is ready: a request is held in an input
// register, the whole state update is done combinationally from it, and the result is
// held in an output register until the master side takes it. Timing registers are to be
// programmed through the APB port only while no request is in flight; the block does not
// enforce this. Counters are COUNT_WIDTH bits wide and saturate.
module gate_opener_controller #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // limit_open, limit_closed, obstruction, command[2:0]
  input  logic        s_axis_tuser,  // op
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // gate_state[3:0], motor_open, motor_close, buzzer, lamp
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import goc_pkg::*;

  goc_cfg_t    cfg;
  goc_item_t   in_item, item_q;
  goc_result_t result_d, result_q;
  logic        in_valid_q, out_valid_q;
  logic        out_free, advance;

  goc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Unpack the incoming request.
  always_comb begin
    in_item.op           = s_axis_tuser;
    in_item.limit_open   = s_axis_tdata[0];
    in_item.limit_closed = s_axis_tdata[1];
    in_item.obstruction  = s_axis_tdata[2];
    in_item.command      = s_axis_tdata[5:3];
  end

  // Handshake: the held request moves on whenever the output register can take it.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= in_item;
    end
  end

  goc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {result_q.lamp, result_q.buzzer, result_q.motor_close,
                          result_q.motor_open, result_q.gate_state};

endmodule

[src/goc_cfg_regs.sv]
module goc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output goc_pkg::goc_cfg_t cfg_o
);
  import goc_pkg::*;

  // Register word indexes.
  localparam logic [2:0] IdxMoveTimeout = 3'd0;
  localparam logic [2:0] IdxEmergHold   = 3'd1;
  localparam logic [2:0] IdxBlinkFast   = 3'd2;
  localparam logic [2:0] IdxBlinkSlow   = 3'd3;
  localparam logic [2:0] IdxErrorBeep   = 3'd4;

  goc_cfg_t    cfg_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // Register file, written in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_timeout_ticks   <= MoveTimeoutRst;
      cfg_q.emergency_hold_ticks <= EmergHoldRst;
      cfg_q.blink_fast_ticks     <= BlinkFastRst;
      cfg_q.blink_slow_ticks     <= BlinkSlowRst;
      cfg_q.error_beep_ticks     <= ErrorBeepRst;
    end else if (wr_en) begin
      case (idx)
        IdxMoveTimeout: cfg_q.move_timeout_ticks   <= pwdata[RegW-1:0];
        IdxEmergHold:   cfg_q.emergency_hold_ticks <= pwdata[RegW-1:0];
        IdxBlinkFast:   cfg_q.blink_fast_ticks     <= pwdata[RegW-1:0];
        IdxBlinkSlow:   cfg_q.blink_slow_ticks     <= pwdata[RegW-1:0];
        IdxErrorBeep:   cfg_q.error_beep_ticks     <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      IdxMoveTimeout: prdata = 32'(cfg_q.move_timeout_ticks);
      IdxEmergHold:   prdata = 32'(cfg_q.emergency_hold_ticks);
      IdxBlinkFast:   prdata = 32'(cfg_q.blink_fast_ticks);
      IdxBlinkSlow:   prdata = 32'(cfg_q.blink_slow_ticks);
      IdxErrorBeep:   prdata = 32'(cfg_q.error_beep_ticks);
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/goc_core.sv]
module goc_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  goc_pkg::goc_item_t   item_i,
  input  goc_pkg::goc_cfg_t    cfg_i,
  output goc_pkg::goc_result_t result_o
);
  import goc_pkg::*;

  typedef enum logic [3:0] {
    MODE_INIT      = 4'd0,
    MODE_WAIT      = 4'd1,
    MODE_CLOSING   = 4'd2,
    MODE_CLOSED    = 4'd3,
    MODE_OPENING   = 4'd4,
    MODE_OPENED    = 4'd5,
    MODE_ERROR     = 4'd6,
    MODE_EMERGENCY = 4'd7,
    MODE_STOP      = 4'd8
  } gate_mode_e;

  // Remote command codes.
  localparam logic [2:0] CmdOpen  = 3'd0;
  localparam logic [2:0] CmdClose = 3'd1;
  localparam logic [2:0] CmdHalt  = 3'd2;
  localparam logic [2:0] CmdReset = 3'd3;
  localparam logic [2:0] CmdEmerg = 3'd4;

  // Compare width covers both the counter and the register.
  localparam int unsigned CmpW = (COUNT_WIDTH > RegW) ? COUNT_WIDTH : RegW;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  gate_mode_e mode_q, mode_d, tgt;
  logic       dir_q, dir_d;
  cnt_t       move_q, move_d, blink_q, blink_d, hold_q, hold_d;
  logic       lamp_q, lamp_d, buzz_q, buzz_d;
  cnt_t       move_inc, blink_inc, hold_inc;
  logic       move_hit, blink_hit, hold_hit;
  logic [RegW-1:0] blink_lim;

  function automatic cnt_t sat_inc(cnt_t c);
    sat_inc = (c == '1) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic reached(cnt_t c, logic [RegW-1:0] lim);
    reached = CmpW'(c) >= CmpW'(lim);
  endfunction

  // Saturating counters and their limit checks.
  always_comb begin
    case (mode_q)
      MODE_OPENING: blink_lim = cfg_i.blink_fast_ticks;
      MODE_CLOSING: blink_lim = cfg_i.blink_slow_ticks;
      default:      blink_lim = cfg_i.error_beep_ticks;
    endcase
    move_inc  = sat_inc(move_q);
    blink_inc = sat_inc(blink_q);
    hold_inc  = sat_inc(hold_q);
    move_hit  = reached(move_inc, cfg_i.move_timeout_ticks);
    blink_hit = reached(blink_inc, blink_lim);
    hold_hit  = reached(hold_inc, cfg_i.emergency_hold_ticks);
  end

  // Next state: pick a target, update counters, then apply entry actions.
  always_comb begin
    mode_d  = mode_q;
    dir_d   = dir_q;
    move_d  = move_q;
    blink_d = blink_q;
    hold_d  = hold_q;
    lamp_d  = lamp_q;
    buzz_d  = buzz_q;
    tgt     = mode_q;

    if (!item_i.op) begin
      if (item_i.limit_open && item_i.limit_closed && mode_q != MODE_ERROR) begin
        tgt = MODE_ERROR;
      end else begin
        case (mode_q)
          MODE_INIT:   tgt = MODE_CLOSED;
          MODE_CLOSED: tgt = item_i.obstruction ? MODE_OPENING : MODE_WAIT;
          MODE_OPENED: tgt = MODE_WAIT;
          MODE_WAIT: begin
            if (item_i.obstruction && item_i.limit_closed) tgt = MODE_OPENING;
          end
          MODE_CLOSING, MODE_OPENING: begin
            if (mode_q == MODE_CLOSING && item_i.obstruction) begin
              tgt = MODE_OPENING;
            end else if (mode_q == MODE_CLOSING && item_i.limit_closed) begin
              tgt = MODE_CLOSED;
            end else if (mode_q == MODE_OPENING && item_i.limit_open) begin
              tgt = MODE_OPENED;
            end else if (mode_q == MODE_OPENING && item_i.obstruction) begin
              tgt = MODE_EMERGENCY;
            end else begin
              move_d = move_inc;
              if (move_hit) begin
                tgt = MODE_ERROR;
              end else if (blink_hit) begin
                lamp_d  = ~lamp_q;
                blink_d = '0;
              end else begin
                blink_d = blink_inc;
              end
            end
          end
          MODE_ERROR: begin
            if (blink_hit) begin
              buzz_d  = ~buzz_q;
              blink_d = '0;
            end else begin
              blink_d = blink_inc;
            end
          end
          MODE_EMERGENCY: begin
            hold_d = hold_inc;
            if (hold_hit) tgt = MODE_WAIT;
          end
          default: ;
        endcase
      end
    end else if (mode_q == MODE_ERROR) begin
      if (item_i.command == CmdEmerg) tgt = MODE_WAIT;
    end else begin
      case (item_i.command)
        CmdOpen: begin
          if (mode_q != MODE_OPENING && mode_q != MODE_OPENED) tgt = MODE_OPENING;
        end
        CmdClose: begin
          if (mode_q != MODE_CLOSING && mode_q != MODE_CLOSED) tgt = MODE_CLOSING;
        end
        CmdHalt: begin
          if (mode_q == MODE_STOP) begin
            tgt = dir_q ? MODE_CLOSING : MODE_OPENING;
          end else if (mode_q == MODE_OPENING || mode_q == MODE_CLOSING) begin
            dir_d = (mode_q == MODE_OPENING);
            tgt   = MODE_STOP;
          end
        end
        CmdReset: tgt = MODE_INIT;
        CmdEmerg: tgt = MODE_EMERGENCY;
        default: ;
      endcase
    end

    // Entry actions happen only on a real change of state.
    if (tgt != mode_q) begin
      mode_d = tgt;
      lamp_d = 1'b0;
      buzz_d = 1'b0;
      case (tgt)
        MODE_OPENING, MODE_CLOSING: begin
          move_d  = '0;
          blink_d = '0;
        end
        MODE_OPENED: lamp_d = 1'b1;
        MODE_ERROR:  blink_d = '0;
        MODE_EMERGENCY: begin
          lamp_d = 1'b1;
          buzz_d = 1'b1;
          hold_d = '0;
        end
        default: ;
      endcase
    end
  end

  // State registers, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INIT;
      dir_q   <= 1'b0;
      move_q  <= '0;
      blink_q <= '0;
      hold_q  <= '0;
      lamp_q  <= 1'b0;
      buzz_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      dir_q   <= dir_d;
      move_q  <= move_d;
      blink_q <= blink_d;
      hold_q  <= hold_d;
      lamp_q  <= lamp_d;
      buzz_q  <= buzz_d;
    end
  end

  // The result shows the state after this update.
  always_comb begin
    result_o.gate_state  = mode_d;
    result_o.motor_open  = (mode_d == MODE_OPENING);
    result_o.motor_close = (mode_d == MODE_CLOSING);
    result_o.buzzer      = buzz_d;
    result_o.lamp        = lamp_d;
  end

  // A tick with both limit switches always ends in error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.op && item_i.limit_open && item_i.limit_closed
    |=> mode_q == MODE_ERROR)
    else $error("both limits did not force error");

  // In error, commands other than emergency leave the state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.op && mode_q == MODE_ERROR && item_i.command != CmdEmerg
    |=> mode_q == MODE_ERROR)
    else $error("error state left without emergency command");

  // Entering emergency turns on both lamp and buzzer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mode_q == MODE_EMERGENCY) |-> lamp_q && buzz_q)
    else $error("emergency entered without lamp and buzzer");

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import goc_pkg::*;

  // Gate states as reported in the result.
  typedef enum logic [3:0] {
    ST_INIT      = 4'd0,
    ST_WAIT      = 4'd1,
    ST_CLOSING   = 4'd2,
    ST_CLOSED    = 4'd3,
    ST_OPENING   = 4'd4,
    ST_OPENED    = 4'd5,
    ST_ERROR     = 4'd6,
    ST_EMERGENCY = 4'd7,
    ST_STOP      = 4'd8
  } gate_mode_e;

  // Remote command codes; the spare codes must be ignored.
  typedef enum logic [2:0] {
    CMD_OPEN      = 3'd0,
    CMD_CLOSE     = 3'd1,
    CMD_HALT      = 3'd2,
    CMD_RESET     = 3'd3,
    CMD_EMERGENCY = 3'd4,
    CMD_SPARE_5   = 3'd5,
    CMD_SPARE_6   = 3'd6,
    CMD_SPARE_7   = 3'd7
  } gate_cmd_e;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_COMMAND = 1'b1
  } req_op_e;

  typedef enum int {
    REG_MOVE_TIMEOUT = 0,
    REG_EMERG_HOLD   = 1,
    REG_BLINK_FAST   = 2,
    REG_BLINK_SLOW   = 3,
    REG_ERROR_BEEP   = 4
  } cfg_reg_e;

  typedef struct packed {
    goc_item_t   req;
    logic        typed;
    goc_result_t res;
  } directed_row_t;

  localparam logic H = 1'b1;
  localparam logic L = 1'b0;
  localparam int DirRows = 25;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 210;
  localparam int SettleCycles = 4;
  localparam int StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // limit_open, limit_closed, obstruction, command[2:0]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // gate_state[3:0], motor_open, motor_close, buzzer, lamp
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the controller state and of its timing registers.
  gate_mode_e  mode_q = ST_INIT;
  logic        dir_q = 1'b0;
  logic [15:0] move_cnt_q = '0;
  logic [15:0] blink_cnt_q = '0;
  logic [15:0] hold_cnt_q = '0;
  logic        lamp_q = 1'b0;
  logic        buzz_q = 1'b0;
  goc_cfg_t    cfg_q = {MoveTimeoutRst, EmergHoldRst, BlinkFastRst, BlinkSlowRst, ErrorBeepRst};

  goc_result_t pending_results[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          stall_cycles = 0;

  // Directed requests, starting from the reset state with reset timing.
  directed_row_t directed_rows [DirRows] = '{
    '{'{OP_TICK,    H, H, L, CMD_OPEN},      H, '{ST_ERROR,     L, L, L, L}}, // both limits
    '{'{OP_COMMAND, L, L, L, CMD_OPEN},      H, '{ST_ERROR,     L, L, L, L}}, // ignored in error
    '{'{OP_COMMAND, L, L, L, CMD_EMERGENCY}, H, '{ST_WAIT,      L, L, L, L}}, // clears error
    '{'{OP_COMMAND, L, L, L, CMD_RESET},     H, '{ST_INIT,      L, L, L, L}},
    '{'{OP_TICK,    L, L, L, CMD_OPEN},      H, '{ST_CLOSED,    L, L, L, L}},
    '{'{OP_TICK,    L, L, H, CMD_OPEN},      H, '{ST_OPENING,   H, L, L, L}},
    '{'{OP_TICK,    L, L, H, CMD_OPEN},      H, '{ST_EMERGENCY, L, L, H, H}},
    '{'{OP_COMMAND, L, L, L, CMD_EMERGENCY}, H, '{ST_EMERGENCY, L, L, H, H}}, // hold kept
    '{'{OP_COMMAND, L, L, L, CMD_CLOSE},     H, '{ST_CLOSING,   L, H, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_HALT},      H, '{ST_STOP,      L, L, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_HALT},      H, '{ST_OPENING,   H, L, L, L}}, // reverses
    '{'{OP_COMMAND, L, L, L, CMD_OPEN},      L, '{ST_INIT,      L, L, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_HALT},      H, '{ST_STOP,      L, L, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_HALT},      H, '{ST_CLOSING,   L, H, L, L}},
    '{'{OP_TICK,    L, L, H, CMD_OPEN},      H, '{ST_OPENING,   H, L, L, L}}, // obstructed
    '{'{OP_TICK,    H, L, L, CMD_OPEN},      H, '{ST_OPENED,    L, L, L, H}},
    '{'{OP_COMMAND, L, L, L, CMD_OPEN},      H, '{ST_OPENED,    L, L, L, H}}, // already open
    '{'{OP_TICK,    L, L, L, CMD_OPEN},      H, '{ST_WAIT,      L, L, L, L}},
    '{'{OP_TICK,    L, H, H, CMD_OPEN},      H, '{ST_OPENING,   H, L, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_SPARE_5},   L, '{ST_INIT,      L, L, L, L}},
    '{'{OP_COMMAND, H, H, H, CMD_SPARE_7},   L, '{ST_INIT,      L, L, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_CLOSE},     H, '{ST_CLOSING,   L, H, L, L}},
    '{'{OP_TICK,    L, H, L, CMD_OPEN},      H, '{ST_CLOSED,    L, L, L, L}},
    '{'{OP_COMMAND, L, L, L, CMD_HALT},      H, '{ST_CLOSED,    L, L, L, L}}, // not moving
    '{'{OP_TICK,    H, H, H, CMD_SPARE_7},   H, '{ST_ERROR,     L, L, L, L}}
  };

  gate_opener_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Counters saturate at their maximum.
  function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
    return (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
  endfunction

  // A change of state resets the outputs; staying put is not an entry.
  function void switch_mode(input gate_mode_e nxt);
    if (nxt != mode_q) begin
      mode_q = nxt;
      lamp_q = 1'b0;
      buzz_q = 1'b0;
      case (nxt)
        ST_OPENING, ST_CLOSING: begin
          move_cnt_q = '0;
          blink_cnt_q = '0;
        end
        ST_OPENED: lamp_q = 1'b1;
        ST_ERROR: blink_cnt_q = '0;
        ST_EMERGENCY: begin
          lamp_q = 1'b1;
          buzz_q = 1'b1;
          hold_cnt_q = '0;
        end
        default: ;
      endcase
    end
  endfunction

  // Lamp blink while the gate moves.
  function void blink_step(input logic [15:0] interval);
    blink_cnt_q = sat_inc(blink_cnt_q);
    if (blink_cnt_q >= interval) begin
      lamp_q = ~lamp_q;
      blink_cnt_q = '0;
    end
  endfunction

  function void tick_step(input logic lo, input logic lc, input logic obs);
    if (lo && lc && mode_q != ST_ERROR) begin
      switch_mode(ST_ERROR);
    end else begin
      case (mode_q)
        ST_INIT: switch_mode(ST_CLOSED);
        ST_CLOSED: begin
          if (obs) switch_mode(ST_OPENING);
          else switch_mode(ST_WAIT);
        end
        ST_OPENED: switch_mode(ST_WAIT);
        ST_WAIT: begin
          if (obs && lc) switch_mode(ST_OPENING);
        end
        ST_CLOSING: begin
          if (obs) begin
            switch_mode(ST_OPENING);
          end else if (lc) begin
            switch_mode(ST_CLOSED);
          end else begin
            move_cnt_q = sat_inc(move_cnt_q);
            if (move_cnt_q >= cfg_q.move_timeout_ticks) switch_mode(ST_ERROR);
            else blink_step(cfg_q.blink_slow_ticks);
          end
        end
        ST_OPENING: begin
          if (lo) begin
            switch_mode(ST_OPENED);
          end else if (obs) begin
            switch_mode(ST_EMERGENCY);
          end else begin
            move_cnt_q = sat_inc(move_cnt_q);
            if (move_cnt_q >= cfg_q.move_timeout_ticks) switch_mode(ST_ERROR);
            else blink_step(cfg_q.blink_fast_ticks);
          end
        end
        ST_ERROR: begin
          blink_cnt_q = sat_inc(blink_cnt_q);
          if (blink_cnt_q >= cfg_q.error_beep_ticks) begin
            buzz_q = ~buzz_q;
            blink_cnt_q = '0;
          end
        end
        ST_EMERGENCY: begin
          hold_cnt_q = sat_inc(hold_cnt_q);
          if (hold_cnt_q >= cfg_q.emergency_hold_ticks) switch_mode(ST_WAIT);
        end
        default: ;
      endcase
    end
  endfunction

  function void command_step(input gate_cmd_e cmd);
    if (mode_q == ST_ERROR) begin
      // Only an emergency command leaves the error state.
      if (cmd == CMD_EMERGENCY) switch_mode(ST_WAIT);
    end else begin
      case (cmd)
        CMD_OPEN: begin
          if (mode_q != ST_OPENING && mode_q != ST_OPENED) switch_mode(ST_OPENING);
        end
        CMD_CLOSE: begin
          if (mode_q != ST_CLOSING && mode_q != ST_CLOSED) switch_mode(ST_CLOSING);
        end
        CMD_HALT: begin
          if (mode_q == ST_STOP) begin
            if (dir_q) switch_mode(ST_CLOSING);
            else switch_mode(ST_OPENING);
          end else if (mode_q == ST_OPENING || mode_q == ST_CLOSING) begin
            dir_q = (mode_q == ST_OPENING);
            switch_mode(ST_STOP);
          end
        end
        CMD_RESET: switch_mode(ST_INIT);
        CMD_EMERGENCY: switch_mode(ST_EMERGENCY);
        default: ;
      endcase
    end
  endfunction

  // Applies one request to the shadow state and returns the gate outputs.
  function goc_result_t gate_predict(input goc_item_t req);
    if (req.op == OP_TICK) tick_step(req.limit_open, req.limit_closed, req.obstruction);
    else command_step(gate_cmd_e'(req.command));
    return '{mode_q, mode_q == ST_OPENING, mode_q == ST_CLOSING, buzz_q, lamp_q};
  endfunction

  function automatic void compare_result(input goc_result_t exp, input logic [7:0] act);
    if (act[3:0] !== exp.gate_state) begin
      $error("gate_state: expected %0d, got %0d", exp.gate_state, act[3:0]);
      fail_count++;
    end
    if (act[4] !== exp.motor_open) begin
      $error("motor_open: expected %0b, got %0b", exp.motor_open, act[4]);
      fail_count++;
    end
    if (act[5] !== exp.motor_close) begin
      $error("motor_close: expected %0b, got %0b", exp.motor_close, act[5]);
      fail_count++;
    end
    if (act[6] !== exp.buzzer) begin
      $error("buzzer: expected %0b, got %0b", exp.buzzer, act[6]);
      fail_count++;
    end
    if (act[7] !== exp.lamp) begin
      $error("lamp: expected %0b, got %0b", exp.lamp, act[7]);
      fail_count++;
    end
  endfunction

  // Presents one request, waits for it to be taken and records its outcome.
  task automatic send_request(input goc_item_t req, input logic typed,
                              input goc_result_t typed_res);
    goc_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.op;
    s_axis_tdata  <= {2'b00, req.command, req.obstruction, req.limit_closed, req.limit_open};
    do @(posedge clk_i); while (!s_axis_tready);
    res = gate_predict(req);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Leaves the input idle until every outstanding result has come back.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen.
  task automatic apb_write(input cfg_reg_e idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Result checker and random backpressure.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h with nothing outstanding", m_axis_tdata);
        fail_count++;
      end else begin
        compare_result(pending_results.pop_front(), m_axis_tdata);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    goc_item_t   req;
    goc_result_t no_res;
    goc_cfg_t    cfg_next;
    logic        quiet;
    int          sense_pct;
    no_res = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset timing.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_and_settle();

      // Timing for this phase: all minimum, all maximum, or short random intervals.
      case (ph)
        1: cfg_next = {5{16'h0001}};
        2: cfg_next = {5{16'hFFFF}};
        default: begin
          cfg_next.move_timeout_ticks   = 16'($urandom_range(12, 1));
          cfg_next.emergency_hold_ticks = 16'($urandom_range(10, 1));
          cfg_next.blink_fast_ticks     = 16'($urandom_range(6, 1));
          cfg_next.blink_slow_ticks     = 16'($urandom_range(6, 1));
          cfg_next.error_beep_ticks     = 16'($urandom_range(6, 1));
          if ($urandom_range(9) == 0) cfg_next.move_timeout_ticks = 16'hFFFF;
          if ($urandom_range(9) == 0) cfg_next.emergency_hold_ticks = 16'hFFFF;
        end
      endcase
      apb_write(REG_MOVE_TIMEOUT, cfg_next.move_timeout_ticks);
      apb_write(REG_EMERG_HOLD, cfg_next.emergency_hold_ticks);
      apb_write(REG_BLINK_FAST, cfg_next.blink_fast_ticks);
      apb_write(REG_BLINK_SLOW, cfg_next.blink_slow_ticks);
      apb_write(REG_ERROR_BEEP, cfg_next.error_beep_ticks);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      cfg_q = cfg_next;

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase

      // Random requests; commands are thinned out while a timer runs and sensor
      // hits while the gate moves, so that timeouts, blinking, beeping and hold expiry occur.
      repeat (ItemsPerPhase) begin
        quiet = mode_q inside {ST_OPENING, ST_CLOSING, ST_EMERGENCY, ST_ERROR};
        sense_pct = (mode_q == ST_OPENING || mode_q == ST_CLOSING) ? 3 : 15;
        req.op = ($urandom_range(99) < (quiet ? 10 : 30)) ? OP_COMMAND : OP_TICK;
        req.limit_open   = ($urandom_range(99) < sense_pct);
        req.limit_closed = ($urandom_range(99) < sense_pct);
        req.obstruction  = ($urandom_range(99) < sense_pct);
        if ($urandom_range(49) == 0) begin
          req.limit_open   = 1'b1;
          req.limit_closed = 1'b1;
        end
        if ($urandom_range(24) == 0) begin
          req.command = 3'($urandom_range(CMD_SPARE_7, CMD_SPARE_5));
        end else begin
          req.command = 3'($urandom_range(CMD_EMERGENCY, CMD_OPEN));
        end
        send_request(req, 1'b0, no_res);
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
